### rtl/bscl_pkg.sv
// Shared types and constants for the button sequence code lock.
package bscl_pkg;

    localparam int MAX_ENTRIES = 12;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = 4;
    localparam int CODE_W      = 24;
    localparam int LEN_W       = 4;
    localparam int IDLE_W      = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CODE_W-1:0] CODE_WORD_RESET   = CODE_W'(71175);
    localparam logic [LEN_W-1:0]  CODE_LENGTH_RESET = LEN_W'(9);
    localparam logic [IDLE_W-1:0] TIMEOUT_RESET     = IDLE_W'(600);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CODE_WORD   = 2'd0,
        CFG_CODE_LENGTH = 2'd1,
        CFG_TIMEOUT     = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        OUTCOME_PENDING  = 2'd0,
        OUTCOME_ACCEPTED = 2'd1,
        OUTCOME_REJECTED = 2'd2,
        OUTCOME_TIMEOUT  = 2'd3
    } outcome_t;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic read_ok;
        logic press_up;
        logic press_down;
        logic press_left;
        logic press_right;
        logic press_submit;
        logic press_clear;
        logic press_other;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        outcome;
        logic [CNT_W-1:0]  entered_count;
        logic [IDLE_W-1:0] idle_count;
    } out_item_t;

endpackage

### rtl/button_sequence_code_lock.sv
// Button sequence code lock: entry store, sequential code compare and idle timeout.
// A tick that does not reach the compare goes through ST_FINISH to the registered result; a submit
// that does first steps through ST_COMPARE entry by entry, stopping at the first mismatch.
// Once finished, the stored outcome is registered straight from idle. One item is in work at a
// time, and the next is taken in the cycle after its result leaves.
// The compare uses a single two-bit comparator. Reset clears all control state.
module button_sequence_code_lock
    import bscl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CODE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_item
);

    state_t            state_reg, state_next;
    logic [CODE_W-1:0] code_word_reg;
    logic [LEN_W-1:0]  code_length_reg;
    logic [IDLE_W-1:0] timeout_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDLE_W-1:0] idle_reg, idle_next;
    logic              finished_reg, finished_next;
    outcome_t          final_reg, final_next;
    logic              sub_reg, sub_next;
    logic              clr_reg, clr_next;
    logic              match_reg, match_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;

    logic [1:0]        entries [MAX_ENTRIES];
    logic              store_en;
    dir_t              store_dir;
    logic              any_press;
    logic [CNT_W-1:0]  cnt_after;
    logic [1:0]        want_code;
    logic [IDLE_W-1:0] idle_inc;
    logic              accept;

    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_word_reg   <= CODE_WORD_RESET;
            code_length_reg <= CODE_LENGTH_RESET;
            timeout_reg     <= TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_CODE_WORD:   code_word_reg   <= cfg_data;
                CFG_CODE_LENGTH: code_length_reg <= cfg_data[LEN_W-1:0];
                CFG_TIMEOUT:     timeout_reg     <= cfg_data[IDLE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            entries[count_reg[IDX_W-1:0]] <= store_dir;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idle_reg      <= '0;
            finished_reg  <= 1'b0;
            final_reg     <= OUTCOME_PENDING;
            sub_reg       <= 1'b0;
            clr_reg       <= 1'b0;
            match_reg     <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idle_reg      <= idle_next;
            finished_reg  <= finished_next;
            final_reg     <= final_next;
            sub_reg       <= sub_next;
            clr_reg       <= clr_next;
            match_reg     <= match_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    always_comb
    begin
        if (in_item.press_up)
        begin
            store_dir = DIR_UP;
        end
        else if (in_item.press_down)
        begin
            store_dir = DIR_DOWN;
        end
        else if (in_item.press_left)
        begin
            store_dir = DIR_LEFT;
        end
        else
        begin
            store_dir = DIR_RIGHT;
        end
    end

    assign any_press = in_item.press_up || in_item.press_down || in_item.press_left
                    || in_item.press_right || in_item.press_submit || in_item.press_clear
                    || in_item.press_other;

    assign store_en = accept && !finished_reg && in_item.read_ok
                   && (in_item.press_up || in_item.press_down || in_item.press_left
                       || in_item.press_right)
                   && (count_reg < code_length_reg)
                   && (count_reg < CNT_W'(MAX_ENTRIES));

    assign cnt_after = store_en ? count_reg + CNT_W'(1) : count_reg;
    assign want_code = 2'(code_word_reg >> {idx_reg, 1'b0});
    assign idle_inc  = (idle_reg == '1) ? idle_reg : idle_reg + IDLE_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idle_next      = idle_reg;
        finished_next  = finished_reg;
        final_next     = final_reg;
        sub_next       = sub_reg;
        clr_next       = clr_reg;
        match_next     = match_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (finished_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_item_next  = '{outcome: final_reg, entered_count: count_reg,
                                          idle_count: idle_reg};
                    end
                    else
                    begin
                        if (in_item.read_ok && any_press)
                        begin
                            idle_next = '0;
                        end
                        count_next = cnt_after;
                        sub_next   = in_item.read_ok && in_item.press_submit;
                        clr_next   = in_item.read_ok && in_item.press_clear;
                        match_next = 1'b0;
                        idx_next   = '0;
                        if (in_item.read_ok && in_item.press_submit
                            && (cnt_after == code_length_reg))
                        begin
                            if (cnt_after == '0)
                            begin
                                match_next = 1'b1;
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                state_next = ST_COMPARE;
                            end
                        end
                        else
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                end
            end

            ST_COMPARE:
            begin
                if (entries[idx_reg] != want_code)
                begin
                    match_next = 1'b0;
                    state_next = ST_FINISH;
                end
                else if (CNT_W'(idx_reg) + CNT_W'(1) == count_reg)
                begin
                    match_next = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            ST_FINISH:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
                if (sub_reg && match_reg)
                begin
                    finished_next = 1'b1;
                    final_next    = OUTCOME_ACCEPTED;
                    out_item_next = '{outcome: OUTCOME_ACCEPTED, entered_count: count_reg,
                                      idle_count: idle_reg};
                end
                else
                begin
                    if (sub_reg || clr_reg)
                    begin
                        count_next = '0;
                    end
                    idle_next = idle_inc;
                    if (idle_inc >= timeout_reg)
                    begin
                        finished_next = 1'b1;
                        final_next    = OUTCOME_TIMEOUT;
                        out_item_next.outcome = OUTCOME_TIMEOUT;
                    end
                    else if (sub_reg)
                    begin
                        out_item_next.outcome = OUTCOME_REJECTED;
                    end
                    else
                    begin
                        out_item_next.outcome = OUTCOME_PENDING;
                    end
                    out_item_next.entered_count = (sub_reg || clr_reg) ? '0 : count_reg;
                    out_item_next.idle_count    = idle_inc;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### verif/tb_button_sequence_code_lock.sv
// Self-checking testbench for the button sequence code lock, with a scoreboard class.
module tb_button_sequence_code_lock
    import bscl_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 16;

    typedef struct packed {
        logic [CODE_W-1:0] code_word;
        logic [LEN_W-1:0]  code_length;
        logic [IDLE_W-1:0] idle_limit;
    } lock_cfg_t;

    typedef struct packed {
        logic [MAX_ENTRIES-1:0][1:0] codes;
        logic [CNT_W-1:0]            count;
        logic [IDLE_W-1:0]           idle;
        logic                        finished;
        logic [1:0]                  final_outcome;
    } lock_state_t;

    class lock_tracker;
        lock_cfg_t   cfg;
        lock_state_t st;
        out_item_t   due_status[$];
        int          mismatches;

        function new();
            cfg.code_word   = CODE_WORD_RESET;
            cfg.code_length = CODE_LENGTH_RESET;
            cfg.idle_limit  = TIMEOUT_RESET;
            st              = '0;
            mismatches      = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CODE_W-1:0] value);
            case (idx)
                CFG_CODE_WORD:   cfg.code_word   = value;
                CFG_CODE_LENGTH: cfg.code_length = value[LEN_W-1:0];
                CFG_TIMEOUT:     cfg.idle_limit  = value[IDLE_W-1:0];
                default:         ;
            endcase
        endfunction

        function out_item_t advance_lock(inout lock_state_t s, input in_item_t it);
            out_item_t  r;
            logic [3:0] dirs;
            logic       match;
            r = '0;
            if (s.finished)
            begin
                r.outcome       = s.final_outcome;
                r.entered_count = s.count;
                r.idle_count    = s.idle;
                return r;
            end
            if (it.read_ok)
            begin
                dirs = {it.press_up, it.press_down, it.press_left, it.press_right};
                if (dirs != 4'd0 || it.press_submit || it.press_clear || it.press_other)
                    s.idle = '0;
                if (s.count < cfg.code_length && s.count < MAX_ENTRIES && dirs != 4'd0)
                begin
                    s.codes[s.count] = it.press_up ? DIR_UP : it.press_down ? DIR_DOWN :
                                       it.press_left ? DIR_LEFT : DIR_RIGHT;
                    s.count = s.count + 1'b1;
                end
                if (it.press_submit)
                begin
                    match = (s.count == cfg.code_length);
                    for (int i = 0; i < MAX_ENTRIES; i++)
                        if (i < s.count && s.codes[i] != cfg.code_word[2*i +: 2])
                            match = 1'b0;
                    if (match)
                    begin
                        s.finished      = 1'b1;
                        s.final_outcome = OUTCOME_ACCEPTED;
                        r.outcome       = OUTCOME_ACCEPTED;
                        r.entered_count = s.count;
                        r.idle_count    = s.idle;
                        return r;
                    end
                    r.outcome = OUTCOME_REJECTED;
                    s.count   = '0;
                    s.codes   = '0;
                end
                if (it.press_clear)
                begin
                    s.count = '0;
                    s.codes = '0;
                end
            end
            if (s.idle != '1)
                s.idle = s.idle + 1'b1;
            if (s.idle >= cfg.idle_limit)
            begin
                s.finished      = 1'b1;
                s.final_outcome = OUTCOME_TIMEOUT;
                r.outcome       = OUTCOME_TIMEOUT;
            end
            r.entered_count = s.count;
            r.idle_count    = s.idle;
            return r;
        endfunction

        function void note_tick(in_item_t it);
            due_status.push_back(advance_lock(st, it));
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (due_status.size() == 0)
            begin
                report("result with no item waiting for it");
                return;
            end
            want = due_status.pop_front();
            if (got.outcome != want.outcome)
                report($sformatf("outcome %0d, expected %0d", got.outcome, want.outcome));
            if (got.entered_count != want.entered_count)
                report($sformatf("entered_count %0d, expected %0d",
                                 got.entered_count, want.entered_count));
            if (got.idle_count != want.idle_count)
                report($sformatf("idle_count %0d, expected %0d",
                                 got.idle_count, want.idle_count));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CODE_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    in_item_t             in_item;
    logic                 out_valid;
    logic                 out_ready;
    out_item_t            out_item;

    lock_tracker sb;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          recv_hold     = 0;
    int          ticks_sent    = 0;
    int          quiet_cycles  = 0;
    bit          ending        = 1'b0;

    button_sequence_code_lock u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (recv_hold > 0)
            begin
                out_ready <= 1'b0;
                recv_hold--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_tick(in_item);
            if (out_valid && out_ready)
                sb.check_result(out_item);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_button_sequence_code_lock failed");
                $finish;
            end
        end
    end

    function automatic in_item_t random_tick();
        return in_item_t'(8'($urandom_range(0, 255)));
    endfunction

    // Outside the closing phase, a tick that would finish the lock is altered so that it cannot.
    task automatic drive(input in_item_t it);
        lock_state_t trial;
        out_item_t   r;
        if (!ending)
        begin
            trial = sb.st;
            r = sb.advance_lock(trial, it);
            if (r.outcome == OUTCOME_TIMEOUT)
            begin
                it.read_ok     = 1'b1;
                it.press_other = 1'b1;
            end
            trial = sb.st;
            r = sb.advance_lock(trial, it);
            if (r.outcome == OUTCOME_ACCEPTED)
            begin
                it.press_submit = 1'b0;
                it.press_other  = 1'b1;
            end
        end
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        ticks_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.due_status.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic configure(input logic [CODE_W-1:0] word, input logic [LEN_W-1:0] len,
                             input logic [IDLE_W-1:0] limit);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_CODE_WORD;
        cfg_data  <= word;
        @(negedge clk);
        cfg_index <= CFG_CODE_LENGTH;
        cfg_data  <= CODE_W'(len);
        @(negedge clk);
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= CODE_W'(limit);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(CFG_CODE_WORD, word);
        sb.write_reg(CFG_CODE_LENGTH, CODE_W'(len));
        sb.write_reg(CFG_TIMEOUT, CODE_W'(limit));
    endtask

    // Keys in the stored code, spoiling one entry or dropping the last unless it is to match.
    task automatic enter_code(input bit correct);
        int         n;
        int         bad;
        bit         short_entry;
        bit         joint;
        logic [3:0] dirs;
        logic [1:0] d;
        in_item_t   it;
        n = (sb.cfg.code_length > MAX_ENTRIES) ? MAX_ENTRIES : int'(sb.cfg.code_length);
        short_entry = !correct && $urandom_range(0, 3) == 0;
        bad = (correct || short_entry) ? -1 : int'($urandom_range(0, n - 1));
        joint = !short_entry && $urandom_range(0, 2) == 0;
        if (sb.st.count != 0 || $urandom_range(0, 3) == 0)
            drive(in_item_t'(8'b1000_0010));
        for (int j = 0; j < n - int'(short_entry); j++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                it = random_tick();
                it.read_ok = 1'b0;
                drive(it);
            end
            d = sb.cfg.code_word[2*j +: 2];
            if (j == bad)
                d = d ^ 2'($urandom_range(1, 3));
            dirs = 4'b1000 >> d;
            if ($urandom_range(0, 3) == 0)
                dirs = dirs | (4'($urandom_range(0, 15)) & (dirs - 4'd1));
            it = '0;
            it.read_ok = 1'b1;
            {it.press_up, it.press_down, it.press_left, it.press_right} = dirs;
            it.press_other  = ($urandom_range(0, 7) == 0);
            it.press_submit = joint && j == n - 1;
            drive(it);
        end
        if (!joint)
        begin
            it = '0;
            it.read_ok      = 1'b1;
            it.press_submit = 1'b1;
            it.press_clear  = ($urandom_range(0, 3) == 0);
            drive(it);
        end
    endtask

    initial
    begin
        int                target;
        logic [CODE_W-1:0] word;
        logic [LEN_W-1:0]  len;
        logic [IDLE_W-1:0] limit;
        in_item_t          it;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_CODE_WORD;
        cfg_data  = '0;
        sb = new();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Bit order of a tick: read_ok, up, down, left, right, submit, clear, other.
        drive(in_item_t'(8'b0000_0000));
        drive(in_item_t'(8'b0111_1111));
        drive(in_item_t'(8'b1000_0000));
        drive(in_item_t'(8'b1111_1000));
        drive(in_item_t'(8'b1011_1000));
        drive(in_item_t'(8'b1001_1000));
        drive(in_item_t'(8'b1000_1000));
        drive(in_item_t'(8'b1000_0001));
        drive(in_item_t'(8'b1000_0100));
        drive(in_item_t'(8'b1010_0000));
        drive(in_item_t'(8'b1100_0110));
        drive(in_item_t'(8'b1001_0010));
        drive(in_item_t'(8'b1111_1111));
        enter_code(1'b0);

        settle();
        configure(24'hFF_FFFF, 4'd15, 16'hFFFF);
        repeat (13) drive(in_item_t'(8'b1000_1000));
        drive(in_item_t'(8'b1000_0100));

        settle();
        configure(24'h00_0000, 4'(MAX_ENTRIES), 16'd8);
        enter_code(1'b0);

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 12 : (mode == 1) ? 80 : 0;
            recv_idle_pct = (mode == 0) ? 80 : (mode == 1) ? 12 : 0;
            for (int part = 0; part < 3; part++)
            begin
                settle();
                case ($urandom_range(0, 3))
                    0:       word = '0;
                    1:       word = '1;
                    default: word = CODE_W'($urandom());
                endcase
                case ($urandom_range(0, 3))
                    0:       len = 4'd1;
                    1:       len = 4'(MAX_ENTRIES);
                    2:       len = 4'($urandom_range(13, 15));
                    default: len = 4'($urandom_range(1, 12));
                endcase
                case ($urandom_range(0, 3))
                    0:       limit = 16'd8;
                    1:       limit = 16'hFFFF;
                    2:       limit = 16'($urandom_range(8, 200));
                    default: limit = 16'($urandom_range(8, 65535));
                endcase
                configure(word, len, limit);
                if (mode == 0 && part == 0)
                    recv_hold = 300;
                target = ticks_sent + 100;
                while (ticks_sent < target)
                begin
                    if ($urandom_range(0, 99) < 70)
                        enter_code(1'b0);
                    else
                        drive(random_tick());
                end
            end
        end

        settle();
        ending = 1'b1;
        case ($urandom_range(0, 4))
            0:
            begin
                configure(CODE_W'($urandom()), 4'($urandom_range(1, 12)), 16'hFFFF);
                enter_code(1'b1);
            end
            1:
            begin
                configure(sb.cfg.code_word, sb.cfg.code_length, 16'($urandom_range(2, 40)));
                while (!sb.st.finished)
                begin
                    it = random_tick();
                    it.read_ok = 1'b0;
                    drive(it);
                end
            end
            2:
            begin
                configure(sb.cfg.code_word, 4'($urandom_range(1, 12)), 16'd1);
                drive(in_item_t'(8'b1000_0100));
            end
            3:
            begin
                configure(sb.cfg.code_word, 4'd0, 16'hFFFF);
                drive(in_item_t'(8'b1100_0100));
            end
            default:
            begin
                configure(sb.cfg.code_word, 4'($urandom_range(1, 12)), 16'd0);
                drive(random_tick());
            end
        endcase
        repeat (20) drive(random_tick());

        in_valid <= 1'b0;
        while (sb.due_status.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (sb.mismatches == 0)
            $display("tb_button_sequence_code_lock passed");
        else
            $display("tb_button_sequence_code_lock failed");
        $finish;
    end

endmodule

### sim.f
rtl/bscl_pkg.sv
rtl/button_sequence_code_lock.sv
verif/tb_button_sequence_code_lock.sv
